// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/bleadv_pkg.sv -----
package bleadv_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic idx_clr;
    logic idx_inc;
    logic load_name;
    logic load_sum;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;
    logic idx_last;
    logic slot_free;
  } dp_stat_t;

endpackage

// ----- src/bleadv_ctrl.sv -----
module bleadv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last_byte,
  output logic                 in_ready,
  input  bleadv_pkg::dp_stat_t stat,
  output bleadv_pkg::ctl_cmd_t cmd
);
  import bleadv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_NAME  = 4'b0100,
    S_SUM   = 4'b1000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && in_last_byte) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_FETCH;
        end
      end
      // buffer read lands at the end of this cycle
      S_FETCH: begin
        state_nxt = stat.len_zero ? S_SUM : S_NAME;
      end
      S_NAME: begin
        if (stat.slot_free) begin
          cmd.load_name = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_nxt     = stat.idx_last ? S_SUM : S_FETCH;
        end
      end
      S_SUM: begin
        if (stat.slot_free) begin
          cmd.load_sum = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/bleadv_dp.sv -----
module bleadv_dp #(
  parameter int NAME_CAPACITY = 29
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_ad_byte,
  input  logic                 in_last_byte,
  input  bleadv_pkg::ctl_cmd_t cmd,
  output bleadv_pkg::dp_stat_t stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [7:0]           out_name_byte,
  output logic                 out_name_found,
  output logic [4:0]           out_name_length,
  output logic                 out_beacon_found,
  output logic [63:0]          out_uuid_high,
  output logic [63:0]          out_uuid_low,
  output logic [15:0]          out_major_value,
  output logic [15:0]          out_minor_value,
  output logic [7:0]           out_tx_power,
  output logic                 out_last
);
  import bleadv_pkg::*;

  localparam int NCW    = $clog2(NAME_CAPACITY + 1);
  localparam int ADDR_W = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;

  localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
  localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;
  localparam logic [7:0] TYPE_MANUF      = 8'hFF;
  localparam logic [7:0] BEACON_MIN_LEN  = 8'd26;
  localparam logic [7:0] POS_PREFIX_LO   = 8'd2;
  localparam logic [7:0] POS_PREFIX_HI   = 8'd5;
  localparam logic [7:0] POS_UUID_HI_LO  = 8'd6;
  localparam logic [7:0] POS_UUID_HI_HI  = 8'd13;
  localparam logic [7:0] POS_UUID_LO_LO  = 8'd14;
  localparam logic [7:0] POS_UUID_LO_HI  = 8'd21;
  localparam logic [7:0] POS_MAJOR_L     = 8'd22;
  localparam logic [7:0] POS_MAJOR_H     = 8'd23;
  localparam logic [7:0] POS_MINOR_L     = 8'd24;
  localparam logic [7:0] POS_MINOR_H     = 8'd25;
  localparam logic [7:0] POS_TX          = 8'd26;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  function automatic logic [7:0] prefix_byte(input logic [1:0] sel);
    logic [7:0] v;
    case (sel)
      2'd0:    v = 8'h4C;
      2'd1:    v = 8'h00;
      2'd2:    v = 8'h02;
      default: v = 8'h15;
    endcase
    return v;
  endfunction

  function automatic logic is_name(input logic [7:0] t);
    return (t == TYPE_SHORT_NAME) || (t == TYPE_FULL_NAME);
  endfunction

  // parse state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       field_len_r, field_len_nxt;
  logic [7:0]       field_type_r, field_type_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic             stopped_r, stopped_nxt;
  logic [NCW-1:0]   name_cnt_r, name_cnt_nxt;
  logic             name_done_r, name_done_nxt;
  logic             name_found_r, name_found_nxt;
  logic             bcn_done_r, bcn_done_nxt;
  logic             bcn_found_r, bcn_found_nxt;
  logic             prefix_ok_r, prefix_ok_nxt;
  logic [63:0]      uuid_hi_r, uuid_hi_nxt;
  logic [63:0]      uuid_lo_r, uuid_lo_nxt;
  logic [15:0]      major_r, major_nxt;
  logic [15:0]      minor_r, minor_nxt;
  logic [7:0]       tx_r, tx_nxt;

  // name buffer
  logic [7:0]        name_mem [NAME_CAPACITY];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] emit_idx_r;
  logic [7:0]        rd_data_r;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_name_byte_r;
  logic        out_name_found_r;
  logic [4:0]  out_name_length_r;
  logic        out_beacon_found_r;
  logic [63:0] out_uuid_high_r;
  logic [63:0] out_uuid_low_r;
  logic [15:0] out_major_r;
  logic [15:0] out_minor_r;
  logic [7:0]  out_tx_r;
  logic        out_last_r;

  logic [7:0]     pos_v;
  logic [7:0]     i_v;
  logic           ncand_v;
  logic           bcand_v;
  logic           over_v;
  logic [NCW-1:0] len_eff;

  always_comb begin
    phase_nxt      = phase_r;
    field_len_nxt  = field_len_r;
    field_type_nxt = field_type_r;
    idx_nxt        = idx_r;
    stopped_nxt    = stopped_r;
    name_cnt_nxt   = name_cnt_r;
    name_done_nxt  = name_done_r;
    name_found_nxt = name_found_r;
    bcn_done_nxt   = bcn_done_r;
    bcn_found_nxt  = bcn_found_r;
    prefix_ok_nxt  = prefix_ok_r;
    uuid_hi_nxt    = uuid_hi_r;
    uuid_lo_nxt    = uuid_lo_r;
    major_nxt      = major_r;
    minor_nxt      = minor_r;
    tx_nxt         = tx_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    i_v            = idx_r + 8'd1;
    pos_v          = i_v - 8'd2;
    ncand_v        = 1'b0;
    bcand_v        = 1'b0;
    over_v         = ({1'b0, field_len_r} - 9'd1) > 9'(NAME_CAPACITY);

    if (cmd.take_byte) begin
      if (!stopped_r) begin
        case (phase_r)
          PH_LEN: begin
            if (in_ad_byte == 8'd0) begin
              stopped_nxt = 1'b1;
            end else begin
              field_len_nxt = in_ad_byte;
              phase_nxt     = PH_TYPE;
            end
          end
          PH_TYPE: begin
            field_type_nxt = in_ad_byte;
            idx_nxt        = 8'd1;
            ncand_v        = is_name(in_ad_byte) && !name_done_r;
            bcand_v        = (in_ad_byte == TYPE_MANUF) && (field_len_r >= BEACON_MIN_LEN)
                             && !bcn_done_r;
            if (!name_done_r) begin
              name_cnt_nxt = '0;
            end
            // drop the name search on an overlong name
            if (ncand_v && over_v) begin
              name_done_nxt = 1'b1;
            end
            if (bcand_v) begin
              prefix_ok_nxt = 1'b1;
              uuid_hi_nxt   = '0;
              uuid_lo_nxt   = '0;
              major_nxt     = '0;
              minor_nxt     = '0;
              tx_nxt        = '0;
            end
            if (field_len_r == 8'd1) begin
              // empty name counts as found
              if (ncand_v && !over_v) begin
                name_done_nxt  = 1'b1;
                name_found_nxt = 1'b1;
              end
              phase_nxt = PH_LEN;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            idx_nxt = i_v;
            ncand_v = is_name(field_type_r) && !name_done_r;
            bcand_v = (field_type_r == TYPE_MANUF) && (field_len_r >= BEACON_MIN_LEN)
                      && !bcn_done_r;
            if (ncand_v && (i_v >= POS_PREFIX_LO)
                && ({1'b0, pos_v} < 9'(NAME_CAPACITY))) begin
              mem_we       = 1'b1;
              mem_waddr    = ADDR_W'(pos_v);
              name_cnt_nxt = NCW'({1'b0, pos_v} + 9'd1);
            end
            if (bcand_v) begin
              if ((i_v >= POS_PREFIX_LO) && (i_v <= POS_PREFIX_HI)) begin
                if (in_ad_byte != prefix_byte(pos_v[1:0])) begin
                  prefix_ok_nxt = 1'b0;
                end
              end else if ((i_v >= POS_UUID_HI_LO) && (i_v <= POS_UUID_HI_HI)) begin
                uuid_hi_nxt = {uuid_hi_r[55:0], in_ad_byte};
              end else if ((i_v >= POS_UUID_LO_LO) && (i_v <= POS_UUID_LO_HI)) begin
                uuid_lo_nxt = {uuid_lo_r[55:0], in_ad_byte};
              end else if (i_v == POS_MAJOR_L) begin
                major_nxt[7:0] = in_ad_byte;
              end else if (i_v == POS_MAJOR_H) begin
                major_nxt[15:8] = in_ad_byte;
              end else if (i_v == POS_MINOR_L) begin
                minor_nxt[7:0] = in_ad_byte;
              end else if (i_v == POS_MINOR_H) begin
                minor_nxt[15:8] = in_ad_byte;
              end else if (i_v == POS_TX) begin
                tx_nxt = in_ad_byte;
              end
            end
            if (i_v >= field_len_r) begin
              if (ncand_v) begin
                name_done_nxt  = 1'b1;
                name_found_nxt = 1'b1;
              end
              if (bcand_v && prefix_ok_nxt) begin
                bcn_done_nxt  = 1'b1;
                bcn_found_nxt = 1'b1;
              end
              phase_nxt = PH_LEN;
            end
          end
          default: phase_nxt = PH_LEN;
        endcase
      end
      // a structure cut by the report end fails open searches
      if (in_last_byte && !stopped_nxt && (phase_nxt != PH_LEN)) begin
        name_done_nxt = 1'b1;
        bcn_done_nxt  = 1'b1;
      end
    end

    if (cmd.load_sum) begin
      phase_nxt      = PH_LEN;
      field_len_nxt  = '0;
      field_type_nxt = '0;
      idx_nxt        = '0;
      stopped_nxt    = 1'b0;
      name_cnt_nxt   = '0;
      name_done_nxt  = 1'b0;
      name_found_nxt = 1'b0;
      bcn_done_nxt   = 1'b0;
      bcn_found_nxt  = 1'b0;
      prefix_ok_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN;
      field_len_r  <= '0;
      field_type_r <= '0;
      idx_r        <= '0;
      stopped_r    <= 1'b0;
      name_cnt_r   <= '0;
      name_done_r  <= 1'b0;
      name_found_r <= 1'b0;
      bcn_done_r   <= 1'b0;
      bcn_found_r  <= 1'b0;
      prefix_ok_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      field_len_r  <= field_len_nxt;
      field_type_r <= field_type_nxt;
      idx_r        <= idx_nxt;
      stopped_r    <= stopped_nxt;
      name_cnt_r   <= name_cnt_nxt;
      name_done_r  <= name_done_nxt;
      name_found_r <= name_found_nxt;
      bcn_done_r   <= bcn_done_nxt;
      bcn_found_r  <= bcn_found_nxt;
      prefix_ok_r  <= prefix_ok_nxt;
    end
  end

  // beacon payload is only reported once found, which follows a clear
  always_ff @(posedge clk) begin
    uuid_hi_r <= uuid_hi_nxt;
    uuid_lo_r <= uuid_lo_nxt;
    major_r   <= major_nxt;
    minor_r   <= minor_nxt;
    tx_r      <= tx_nxt;
  end

  // name buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      name_mem[mem_waddr] <= in_ad_byte;
    end
    rd_data_r <= name_mem[emit_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.idx_clr) begin
      emit_idx_r <= '0;
    end else if (cmd.idx_inc) begin
      emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  assign len_eff        = name_found_r ? name_cnt_r : '0;
  assign stat.len_zero  = (len_eff == '0);
  assign stat.idx_last  = (((NCW + 1)'(emit_idx_r) + 1'b1) == (NCW + 1)'(len_eff));
  assign stat.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_name || cmd.load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_name) begin
      out_kind_r         <= 1'b0;
      out_name_byte_r    <= rd_data_r;
      out_name_found_r   <= 1'b0;
      out_name_length_r  <= '0;
      out_beacon_found_r <= 1'b0;
      out_uuid_high_r    <= '0;
      out_uuid_low_r     <= '0;
      out_major_r        <= '0;
      out_minor_r        <= '0;
      out_tx_r           <= '0;
      out_last_r         <= 1'b0;
    end else if (cmd.load_sum) begin
      out_kind_r         <= 1'b1;
      out_name_byte_r    <= '0;
      out_name_found_r   <= name_found_r;
      out_name_length_r  <= 5'(len_eff);
      out_beacon_found_r <= bcn_found_r;
      out_uuid_high_r    <= bcn_found_r ? uuid_hi_r : '0;
      out_uuid_low_r     <= bcn_found_r ? uuid_lo_r : '0;
      out_major_r        <= bcn_found_r ? major_r : '0;
      out_minor_r        <= bcn_found_r ? minor_r : '0;
      out_tx_r           <= bcn_found_r ? tx_r : '0;
      out_last_r         <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_name_byte    = out_name_byte_r;
  assign out_name_found   = out_name_found_r;
  assign out_name_length  = out_name_length_r;
  assign out_beacon_found = out_beacon_found_r;
  assign out_uuid_high    = out_uuid_high_r;
  assign out_uuid_low     = out_uuid_low_r;
  assign out_major_value  = out_major_r;
  assign out_minor_value  = out_minor_r;
  assign out_tx_power     = out_tx_r;
  assign out_last         = out_last_r;

endmodule

// ----- src/ble_adv_data_name_beacon_parser_unit.sv -----
// BLE advertising-data parser. Feed the advertising-data bytes of one report, one
// word per byte, and flag the final byte with in_last_byte. The block walks the
// length-type-value structures, buffers the first shortened or complete local
// name if it fits NAME_CAPACITY bytes, and captures UUID, major, minor and tx power
// from the first manufacturer structure of at least 26 bytes carrying the iBeacon
// prefix 4C 00 02 15. A zero length byte ends parsing until the report's final
// byte; a structure cut short by the final byte fails any search still open.
// After the final byte the block sends the buffered name bytes (out_kind low),
// then one summary word (out_kind and out_last high) and is ready for the next
// report. Throughput: while parsing, one byte per cycle. From the final byte on,
// the input is held off while the name bytes go out: the name buffer
// has a registered read port and the next byte is fetched only after the current
// one is handed to the output register; the summary word follows, after a
// single fetch state when there is no name, and out_ready stalls extend the
// hold-off. The output register lets the next report's bytes enter while the
// summary word still waits to be taken.
`include "assert_macros.svh"

module ble_adv_data_name_beacon_parser_unit #(
  parameter int NAME_CAPACITY = 29
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ad_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_name_byte,
  output logic        out_name_found,
  output logic [4:0]  out_name_length,
  output logic        out_beacon_found,
  output logic [63:0] out_uuid_high,
  output logic [63:0] out_uuid_low,
  output logic [15:0] out_major_value,
  output logic [15:0] out_minor_value,
  output logic [7:0]  out_tx_power,
  output logic        out_last
);
  import bleadv_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Controller: accepts bytes, then sequences name and summary emission.
  bleadv_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath: parse state, name buffer, beacon capture and output register.
  bleadv_dp #(
    .NAME_CAPACITY (NAME_CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ad_byte       (in_ad_byte),
    .in_last_byte     (in_last_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_name_byte    (out_name_byte),
    .out_name_found   (out_name_found),
    .out_name_length  (out_name_length),
    .out_beacon_found (out_beacon_found),
    .out_uuid_high    (out_uuid_high),
    .out_uuid_low     (out_uuid_low),
    .out_major_value  (out_major_value),
    .out_minor_value  (out_minor_value),
    .out_tx_power     (out_tx_power),
    .out_last         (out_last)
  );

  // Hold off input right after the final byte of a report.
  `ASSERT_NEXT(a_hold_after_last, clk, rst_n, in_valid && in_ready && in_last_byte, !in_ready)
  // Only the summary word closes a report.
  `ASSERT_IMPLY(a_kind_last, clk, rst_n, out_valid, out_kind == out_last)
  // No name found means no name length reported.
  `ASSERT_IMPLY(a_name_len, clk, rst_n, out_valid && out_kind && !out_name_found,
                out_name_length == 5'd0)
  // No beacon found means zeroed beacon fields.
  `ASSERT_IMPLY(a_beacon_zero, clk, rst_n, out_valid && !out_beacon_found,
                (out_uuid_high == 64'd0) && (out_tx_power == 8'd0))

endmodule

// ----- sim/tb.sv -----
// Testbench for the BLE advertising-data name and iBeacon parser.
// Drive advertising-data bytes as words on the input channel and mark the last
// byte of each report. An in-house predictor mirrors the parser state byte by
// byte and queues the name-byte words and the summary word that each report
// must produce. Compare every output word against the oldest queued word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Parser configuration and the codes that matter to it.
  localparam int NAME_CAPACITY = 29;
  localparam int BEACON_MIN_LEN = 26;
  localparam logic [7:0] AD_SHORT_NAME = 8'h08;
  localparam logic [7:0] AD_FULL_NAME = 8'h09;
  localparam logic [7:0] AD_MANUF = 8'hFF;
  // Manufacturer data must open with company 0x004C (low byte first) and 02 15.
  localparam logic [31:0] BEACON_PREFIX = 32'h4C00_0215;

  // Where the predictor stands inside a length-type-value structure.
  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // Search flags: low bit says the search is over, high bit says it succeeded.
  localparam logic [1:0] SRCH_DONE = 2'b01;
  localparam logic [1:0] SRCH_FOUND = 2'b10;

  // Stimulus size: the tail after CALM_AFTER words runs with no idling.
  localparam int WORDS_TOTAL = 470;
  localparam int CALM_AFTER = 400;

  // One word on the result channel.
  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        name_found;
    logic [4:0]  name_length;
    logic        beacon_found;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic [15:0] major_value;
    logic [15:0] minor_value;
    logic [7:0]  tx_power;
    logic        last;
  } adv_word_t;

  // One directed row: the input byte, and for rows whose summary is obvious,
  // the summary typed in by hand (beacon fields are then always zero).
  typedef struct packed {
    logic [7:0] ad;
    logic       fin;
    logic       typed;
    logic       t_name_found;
    logic [4:0] t_name_length;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ad_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_name_byte;
  logic        out_name_found;
  logic [4:0]  out_name_length;
  logic        out_beacon_found;
  logic [63:0] out_uuid_high;
  logic [63:0] out_uuid_low;
  logic [15:0] out_major_value;
  logic [15:0] out_minor_value;
  logic [7:0]  out_tx_power;
  logic        out_last;

  ble_adv_data_name_beacon_parser_unit #(
    .NAME_CAPACITY(NAME_CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ad_byte(in_ad_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_name_byte(out_name_byte),
    .out_name_found(out_name_found),
    .out_name_length(out_name_length),
    .out_beacon_found(out_beacon_found),
    .out_uuid_high(out_uuid_high),
    .out_uuid_low(out_uuid_low),
    .out_major_value(out_major_value),
    .out_minor_value(out_minor_value),
    .out_tx_power(out_tx_power),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  // Predictor copy of the parser state.
  logic [1:0]  ph;
  logic [7:0]  fld_len;
  logic [7:0]  fld_type;
  logic [7:0]  fld_idx;
  logic        stopped;
  logic [7:0]  name_buf [NAME_CAPACITY];
  int          name_cnt;
  logic [1:0]  name_flags;
  logic [1:0]  bcn_flags;
  logic        prefix_ok;
  logic [63:0] uuid_hi;
  logic [63:0] uuid_lo;
  logic [15:0] major;
  logic [15:0] minor;
  logic [7:0]  tx_pwr;

  adv_word_t words_due [$];   // words the parser still owes, oldest first
  adv_word_t step_words [$];  // words caused by the byte just taken

  bit calm;
  int words_in;
  int reports_in;
  int words_checked;
  int names_seen;
  int beacons_seen;
  int mismatches;
  int gap_free;

  // The name search is open and the current structure carries a name.
  function automatic bit name_cand();
    return (fld_type == AD_SHORT_NAME || fld_type == AD_FULL_NAME) &&
           (name_flags & SRCH_DONE) == 2'b00;
  endfunction

  // The beacon search is open and the current structure is long manufacturer data.
  function automatic bit bcn_cand();
    return fld_type == AD_MANUF && int'(fld_len) >= BEACON_MIN_LEN &&
           (bcn_flags & SRCH_DONE) == 2'b00;
  endfunction

  task automatic clear_parse();
    ph = PH_LENGTH;
    fld_len = '0;
    fld_type = '0;
    fld_idx = '0;
    stopped = 1'b0;
    name_cnt = 0;
    name_flags = '0;
    bcn_flags = '0;
    prefix_ok = 1'b0;
    uuid_hi = '0;
    uuid_lo = '0;
    major = '0;
    minor = '0;
    tx_pwr = '0;
  endtask

  // A structure is complete: settle whichever search it was a candidate for.
  task automatic close_field();
    if (name_cand()) name_flags = SRCH_DONE | SRCH_FOUND;
    if (bcn_cand() && prefix_ok) bcn_flags = SRCH_DONE | SRCH_FOUND;
    ph = PH_LENGTH;
  endtask

  // Advance the predictor by one accepted byte; queue what it causes in step_words.
  task automatic parse_ad_word(input logic [7:0] b, input logic fin);
    adv_word_t w;
    int i;
    int len;
    bit nf;
    bit bf;
    if (!stopped) begin
      if (ph == PH_LENGTH) begin
        // A zero length stops parsing until the report ends.
        if (b == 8'h00) begin
          stopped = 1'b1;
        end else begin
          fld_len = b;
          ph = PH_TYPE;
        end
      end else if (ph == PH_TYPE) begin
        fld_type = b;
        fld_idx = 8'd1;
        if ((name_flags & SRCH_DONE) == 2'b00) name_cnt = 0;
        // A name that cannot fit ends the name search empty-handed.
        if (name_cand() && int'(fld_len) - 1 > NAME_CAPACITY) name_flags = SRCH_DONE;
        if (bcn_cand()) begin
          prefix_ok = 1'b1;
          uuid_hi = '0;
          uuid_lo = '0;
          major = '0;
          minor = '0;
          tx_pwr = '0;
        end
        if (fld_len == 8'd1) close_field();
        else ph = PH_DATA;
      end else begin
        fld_idx = fld_idx + 8'd1;
        i = int'(fld_idx);
        if (name_cand() && i >= 2 && i - 2 < NAME_CAPACITY) begin
          name_buf[i - 2] = b;
          name_cnt = i - 1;
        end
        if (bcn_cand()) begin
          if (i >= 2 && i <= 5) begin
            if (b != BEACON_PREFIX[8 * (5 - i) +: 8]) prefix_ok = 1'b0;
          end else if (i >= 6 && i <= 13) begin
            uuid_hi = {uuid_hi[55:0], b};
          end else if (i >= 14 && i <= 21) begin
            uuid_lo = {uuid_lo[55:0], b};
          end else if (i == 22) begin
            major[7:0] = b;
          end else if (i == 23) begin
            major[15:8] = b;
          end else if (i == 24) begin
            minor[7:0] = b;
          end else if (i == 25) begin
            minor[15:8] = b;
          end else if (i == 26) begin
            tx_pwr = b;
          end
        end
        if (fld_idx >= fld_len) close_field();
      end
    end

    if (fin) begin
      // A structure cut off by the report end fails every open search.
      if (!stopped && ph != PH_LENGTH) begin
        if ((name_flags & SRCH_DONE) == 2'b00) name_flags = SRCH_DONE;
        if ((bcn_flags & SRCH_DONE) == 2'b00) bcn_flags = SRCH_DONE;
      end
      nf = (name_flags & SRCH_FOUND) != 2'b00;
      bf = (bcn_flags & SRCH_FOUND) != 2'b00;
      len = nf ? name_cnt : 0;
      for (int k = 0; k < len && k < NAME_CAPACITY; k++) begin
        w = '0;
        w.name_byte = name_buf[k];
        step_words.push_back(w);
      end
      w = '0;
      w.kind = 1'b1;
      w.name_found = nf;
      w.name_length = len[4:0];
      w.beacon_found = bf;
      if (bf) begin
        w.uuid_high = uuid_hi;
        w.uuid_low = uuid_lo;
        w.major_value = major;
        w.minor_value = minor;
        w.tx_power = tx_pwr;
      end
      w.last = 1'b1;
      step_words.push_back(w);
      clear_parse();
    end
  endtask

  // Send one byte word: maybe idle first, hold it until taken, then predict.
  // A typed row replaces the predicted words with its hand-written summary.
  task automatic push_word(input logic [7:0] b, input logic fin, input logic typed,
                           input logic t_nf, input logic [4:0] t_len);
    adv_word_t w;
    calm = words_in >= CALM_AFTER;
    if (gap_free > 0) begin
      gap_free--;
    end else if (!calm && $urandom_range(0, 39) == 0) begin
      gap_free = $urandom_range(20, 80);
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ad_byte <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    words_in++;
    if (fin) reports_in++;
    parse_ad_word(b, fin);
    if (typed) begin
      step_words.delete();
      w = '0;
      w.kind = 1'b1;
      w.name_found = t_nf;
      w.name_length = t_len;
      w.last = 1'b1;
      words_due.push_back(w);
    end else begin
      foreach (step_words[k]) words_due.push_back(step_words[k]);
      step_words.delete();
    end
  endtask

  // Stop sending until the parser has handed over everything it owes.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] want,
                           input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Check every output word taken by the receiver against the oldest one due.
  always @(posedge clk) begin : result_check
    adv_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        $display("%0t ns: unexpected output word, expected none, actual kind %b byte %h",
                 $time, out_kind, out_name_byte);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        words_checked++;
        if (want.name_found && want.last) names_seen++;
        if (want.beacon_found) beacons_seen++;
        cmp_field("kind", want.kind, out_kind);
        cmp_field("name_byte", want.name_byte, out_name_byte);
        cmp_field("name_found", want.name_found, out_name_found);
        cmp_field("name_length", want.name_length, out_name_length);
        cmp_field("beacon_found", want.beacon_found, out_beacon_found);
        cmp_field("uuid_high", want.uuid_high, out_uuid_high);
        cmp_field("uuid_low", want.uuid_low, out_uuid_low);
        cmp_field("major_value", want.major_value, out_major_value);
        cmp_field("minor_value", want.minor_value, out_minor_value);
        cmp_field("tx_power", want.tx_power, out_tx_power);
        cmp_field("last", want.last, out_last);
      end
    end
  end

  // Receiver: stall in random bursts, with long free stretches,
  // and never once the calm tail of the run has started.
  int stall_left = 0;
  int run_left = 0;
  always @(posedge clk) begin
    if (calm) stall_left = 0;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) run_left = $urandom_range(20, 120);
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    dir_row_t directed_rows [22];
    logic [7:0] rpt [$];
    logic [7:0] ftype;
    logic [7:0] pbyte;
    int nstruct;
    int sel;
    int flen;
    int bad_at;
    int cut;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ad_byte = '0;
    in_last_byte = 1'b0;
    calm = 1'b0;
    words_in = 0;
    reports_in = 0;
    words_checked = 0;
    names_seen = 0;
    beacons_seen = 0;
    mismatches = 0;
    gap_free = 0;
    clear_parse();

    // Directed reports, one row per byte:
    //   zero length as the only byte;
    //   empty name (length 1, complete name type);
    //   name too long for the buffer, then cut off;
    //   name with extreme byte values (00, FF, 80);
    //   zero length after a flags structure, trailing bytes ignored;
    //   a lone nonzero length as the final byte;
    //   manufacturer data too short to be a beacon.
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, 1'b0, 5'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h09, 1'b1, 1'b1, 1'b1, 5'd0},
      '{8'h1F, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h08, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h41, 1'b1, 1'b1, 1'b0, 5'd0},
      '{8'h04, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h09, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 5'd0},
      '{8'h02, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h06, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'hAA, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h55, 1'b1, 1'b1, 1'b0, 5'd0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 5'd0},
      '{8'h03, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h4C, 1'b0, 1'b0, 1'b0, 5'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 5'd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      push_word(directed_rows[r].ad, directed_rows[r].fin, directed_rows[r].typed,
                directed_rows[r].t_name_found, directed_rows[r].t_name_length);

    // Drain once before the random reports start.
    hold_until_drained();

    // Random reports: mostly well-formed structures with random content, some
    // with a broken beacon prefix, some stopped by a zero length, some cut short.
    while (words_in < WORDS_TOTAL) begin
      rpt.delete();
      nstruct = $urandom_range(1, 3);
      for (int s = 0; s < nstruct; s++) begin
        sel = $urandom_range(0, 9);
        if (sel == 9) begin
          // Terminate parsing and trail a few ignored bytes.
          rpt.push_back(8'h00);
          repeat ($urandom_range(0, 4)) rpt.push_back(8'($urandom_range(0, 255)));
          break;
        end
        bad_at = 0;
        if (sel <= 3) begin
          ftype = $urandom_range(0, 1) ? AD_FULL_NAME : AD_SHORT_NAME;
          // Occasionally straddle the buffer size: just under, full fit, one over, more.
          flen = ($urandom_range(0, 6) == 0) ?
                 $urandom_range(NAME_CAPACITY - 1, NAME_CAPACITY + 3) :
                 $urandom_range(1, 12);
        end else if (sel <= 5) begin
          ftype = AD_MANUF;
          flen = $urandom_range(BEACON_MIN_LEN, BEACON_MIN_LEN + 4);
          if ($urandom_range(0, 3) == 0) bad_at = $urandom_range(2, 5);
        end else if (sel <= 7) begin
          ftype = 8'($urandom_range(0, 255));
          flen = $urandom_range(1, 8);
        end else begin
          ftype = AD_MANUF;
          flen = $urandom_range(2, BEACON_MIN_LEN - 1);
        end
        rpt.push_back(8'(flen));
        rpt.push_back(ftype);
        for (int d = 2; d <= flen; d++) begin
          if (ftype == AD_MANUF && d <= 5) begin
            pbyte = BEACON_PREFIX[8 * (5 - d) +: 8];
            if (d == bad_at) pbyte = pbyte ^ 8'($urandom_range(1, 255));
            rpt.push_back(pbyte);
          end else begin
            rpt.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      // Cut some reports mid-structure, the final byte possibly a length.
      if (rpt.size() > 1 && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, rpt.size() - 1);
        while (rpt.size() > cut) void'(rpt.pop_back());
      end
      foreach (rpt[k])
        push_word(rpt[k], k == rpt.size() - 1, 1'b0, 1'b0, 5'd0);
      if (!calm && $urandom_range(0, 5) == 0) hold_until_drained();
    end

    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (2 * NAME_CAPACITY + 16) @(posedge clk);

    $display("Covered %0d reports from %0d input bytes; %0d output words checked.",
             reports_in, words_in, words_checked);
    $display("Summaries with a name found: %0d, with a beacon found: %0d.",
             names_seen, beacons_seen);
    if (mismatches == 0) begin
      $display("ble_adv_data_name_beacon_parser_unit verification clean");
    end else begin
      $display("ble_adv_data_name_beacon_parser_unit verification failed");
    end
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #10000000;
    $display("ble_adv_data_name_beacon_parser_unit verification failed");
    $finish;
  end

endmodule
